/* hdl/tlpr_pkg.sv */
`default_nettype none

package tlpr_pkg;

  // Joint store sizing
  localparam int NUM_JOINTS  = 16;
  localparam int JOINT_W     = 4;
  localparam int STORE_DEPTH = (NUM_JOINTS > (1 << JOINT_W)) ? (1 << JOINT_W) : NUM_JOINTS;
  localparam int JIDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [JOINT_W:0] JOINT_LIMIT = (JOINT_W + 1)'(STORE_DEPTH);

  // Q1.16 unity and register reset values
  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [15:0] SHRINK_RESET  = 16'd58982;
  localparam logic [23:0] RELEASE_RESET = 24'd72818;

  // Register map (index is paddr[2])
  localparam logic [0:0] REG_SHRINK  = 1'b0;
  localparam logic [0:0] REG_RELEASE = 1'b1;

  typedef struct packed {
    logic [JOINT_W-1:0] joint;
    logic signed [31:0] current_pos;
    logic signed [31:0] desired_pos;
    logic signed [31:0] torque;
    logic [30:0]        torque_limit;
    logic               torque_present;
  } in_item_t;

  typedef struct packed {
    logic [JOINT_W-1:0] out_joint;
    logic signed [31:0] reference_pos;
    logic [16:0]        applied_factor;
  } out_item_t;

  typedef struct packed {
    logic [15:0] shrink_gain;
    logic [23:0] release_gain;
  } cfg_t;

  // Microcode
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t LAST_STEP = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD,
    OP_MUL_GAIN,
    OP_ROUND,
    OP_MUL_REF,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_IN,
    COND_NO_UPD,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic  accept;
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic upd;
    logic out_busy;
  } stat_t;

  // Control store: one word per step
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{accept: 1'b0, op: OP_NONE, cond: COND_ALWAYS, target: 3'd0};
    case (s)
      3'd0: w = '{accept: 1'b1, op: OP_CAPTURE,  cond: COND_NO_IN,    target: 3'd0};
      3'd1: w = '{accept: 1'b0, op: OP_LOAD,     cond: COND_NO_UPD,   target: 3'd4};
      3'd2: w = '{accept: 1'b0, op: OP_MUL_GAIN, cond: COND_NONE,     target: 3'd0};
      3'd3: w = '{accept: 1'b0, op: OP_ROUND,    cond: COND_NONE,     target: 3'd0};
      3'd4: w = '{accept: 1'b0, op: OP_MUL_REF,  cond: COND_NONE,     target: 3'd0};
      3'd5: w = '{accept: 1'b0, op: OP_OUT,      cond: COND_OUT_BUSY, target: 3'd5};
      default: w = '{accept: 1'b0, op: OP_NONE,  cond: COND_ALWAYS,   target: 3'd0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/tlpr_seq.sv */
`default_nettype none

module tlpr_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire tlpr_pkg::stat_t  stat,
  output tlpr_pkg::uword_t      uw
);

  tlpr_pkg::step_t step;
  tlpr_pkg::step_t step_next;
  logic            taken;

  assign uw = tlpr_pkg::ucode(step);

  // Branch condition
  always_comb begin
    case (uw.cond)
      tlpr_pkg::COND_NONE:     taken = 1'b0;
      tlpr_pkg::COND_ALWAYS:   taken = 1'b1;
      tlpr_pkg::COND_NO_IN:    taken = !in_valid;
      tlpr_pkg::COND_NO_UPD:   taken = !stat.upd;
      tlpr_pkg::COND_OUT_BUSY: taken = stat.out_busy;
      default:                 taken = 1'b1;
    endcase
  end

  always_comb begin
    if (taken) begin
      step_next = uw.target;
    end else if (step == tlpr_pkg::LAST_STEP) begin
      step_next = '0;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/tlpr_dp.sv */
`default_nettype none

module tlpr_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tlpr_pkg::uword_t     uw,
  input  wire tlpr_pkg::cfg_t       cfg,
  input  wire logic                 in_valid,
  input  wire tlpr_pkg::in_item_t   in_item,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output tlpr_pkg::out_item_t       out_item,
  output tlpr_pkg::stat_t           stat
);

  // Captured item
  tlpr_pkg::in_item_t item;

  // Working registers
  logic [16:0]        f;
  logic               shrink;
  logic signed [32:0] motion;
  logic signed [58:0] prod;

  // Factor store with per-entry valid bits (invalid reads as 1.0)
  logic [16:0]                      store [tlpr_pkg::STORE_DEPTH];
  logic [tlpr_pkg::STORE_DEPTH-1:0] fvalid;

  logic [tlpr_pkg::JIDX_W-1:0] idx;
  logic                        in_range;
  logic [16:0]                 f_rd;

  assign idx      = item.joint[tlpr_pkg::JIDX_W-1:0];
  assign in_range = {1'b0, item.joint} < tlpr_pkg::JOINT_LIMIT;
  assign f_rd     = (in_range && fvalid[idx]) ? store[idx] : tlpr_pkg::ONE_Q16;

  // Direction test on the captured item
  logic signed [32:0] tq_x;
  logic signed [32:0] lim_x;
  logic               shrink_c;

  assign tq_x     = {item.torque[31], item.torque};
  assign lim_x    = {2'b00, item.torque_limit};
  assign shrink_c = ((tq_x > lim_x) && (item.desired_pos > item.current_pos)) ||
                    ((tq_x < -lim_x) && (item.desired_pos < item.current_pos));

  // Shared multiplier operands
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic [23:0]        gain;

  assign gain = shrink ? {8'd0, cfg.shrink_gain} : cfg.release_gain;

  always_comb begin
    if (uw.op == tlpr_pkg::OP_MUL_GAIN) begin
      mul_a = {17'd0, f};
      mul_b = {1'b0, gain};
    end else begin
      mul_a = {motion[32], motion};
      mul_b = {8'd0, f};
    end
  end

  // Ceiling of factor times gain, clamped to 1.0
  logic [41:0] rnd;
  logic [25:0] q_f;
  logic [16:0] f_round;

  assign rnd     = {1'b0, prod[40:0]} + 42'd65535;
  assign q_f     = rnd[41:16];
  assign f_round = (q_f > 26'd65536) ? tlpr_pkg::ONE_Q16 : q_f[16:0];

  // Reference: current plus floored scaled motion, saturated
  logic signed [32:0] q_ref;
  logic signed [33:0] sum;
  logic signed [31:0] ref_sat;

  assign q_ref = prod[48:16];
  assign sum   = {{2{item.current_pos[31]}}, item.current_pos} + {q_ref[32], q_ref};

  always_comb begin
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      ref_sat = sum[31:0];
    end else if (sum[33]) begin
      ref_sat = 32'sh8000_0000;
    end else begin
      ref_sat = 32'sh7fff_ffff;
    end
  end

  // Update decision comes straight from the captured item, read at the load step
  logic out_busy;
  assign out_busy      = out_valid && !out_ready;
  assign stat.upd      = item.torque_present && in_range;
  assign stat.out_busy = out_busy;

  // Payload registers
  always_ff @(posedge clk) begin
    case (uw.op)
      tlpr_pkg::OP_CAPTURE: begin
        if (in_valid) begin
          item <= in_item;
        end
      end
      tlpr_pkg::OP_LOAD: begin
        f      <= f_rd;
        shrink <= shrink_c;
        motion <= {item.desired_pos[31], item.desired_pos} -
                  {item.current_pos[31], item.current_pos};
      end
      tlpr_pkg::OP_MUL_GAIN: begin
        prod <= mul_a * mul_b;
      end
      tlpr_pkg::OP_ROUND: begin
        f          <= f_round;
        store[idx] <= f_round;
      end
      tlpr_pkg::OP_MUL_REF: begin
        prod <= mul_a * mul_b;
      end
      tlpr_pkg::OP_OUT: begin
        if (!out_busy) begin
          out_item.out_joint      <= item.joint;
          out_item.reference_pos  <= ref_sat;
          out_item.applied_factor <= f;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (uw.op == tlpr_pkg::OP_ROUND) begin
        fvalid[idx] <= 1'b1;
      end
      if (uw.op == tlpr_pkg::OP_OUT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/torque_limited_position_reference.sv */
// Torque-limited position reference.
// Input channel in_valid/in_ready/in_item carries one joint sample; output
// channel out_valid/out_ready/out_item returns one reference item per sample.
// A per-joint Q1.16 factor shrinks by shrink_gain while torque pushes past the
// limit in the direction of motion and recovers by release_gain otherwise; the
// reference is current_pos plus the floored product of motion and factor.
// Gains are set through the APB port: shrink_gain at 0x0, release_gain at 0x4.
// Timing: a six-step control program runs per item (capture, load, gain
// multiply, round and write back, reference multiply, output). Items without
// a torque update skip two steps. A new item is accepted only once the
// program is back at its capture step; the shared multiplier and the step
// counter make the steps of one item run one after another.
// The result sits in an output register, so a new item is taken while the
// previous result waits; if the receiver is still stalling when the next
// result is ready, the program holds at its output step until it is free.
// Reset: all joint factors read as 1.0, gains return to defaults, no result
// is pending and the block is ready for input on the next cycle.
`default_nettype none

module torque_limited_position_reference (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tlpr_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tlpr_pkg::out_item_t       out_item,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  tlpr_pkg::cfg_t   cfg;
  tlpr_pkg::uword_t uw;
  tlpr_pkg::stat_t  stat;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shrink_gain  <= tlpr_pkg::SHRINK_RESET;
      cfg.release_gain <= tlpr_pkg::RELEASE_RESET;
    end else if (wr_en) begin
      case (paddr[2:2])
        tlpr_pkg::REG_SHRINK:  cfg.shrink_gain  <= pwdata[15:0];
        tlpr_pkg::REG_RELEASE: cfg.release_gain <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2:2])
      tlpr_pkg::REG_SHRINK:  prdata = {16'd0, cfg.shrink_gain};
      tlpr_pkg::REG_RELEASE: prdata = {8'd0, cfg.release_gain};
      default:               prdata = '0;
    endcase
  end

  // Step sequencer
  tlpr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .uw       (uw)
  );

  assign in_ready = uw.accept;

  // Datapath
  tlpr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .uw        (uw),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .stat      (stat)
  );

  // One item in flight: the program leaves the capture step once an item is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in progress");

  // Factor never leaves [0, 1.0]
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.applied_factor <= tlpr_pkg::ONE_Q16)
    else $error("applied factor above 1.0");

  // After reset nothing is pending and input is open
  assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

`default_nettype wire
